// ===== design/aes_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES package
// Shared types, constants and byte-level functions for the AES-128 encryptor.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int NUM_ROUNDS = 10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_KEYX,
        ST_RUN
    } state_t;

    typedef logic [7:0] sbox_tab_t [256];

    localparam sbox_tab_t SBOX = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [1:0] CFG_KEY_HIGH = 2'd0;
    localparam logic [1:0] CFG_KEY_LOW  = 2'd1;

    function automatic logic [7:0] xtime(input logic [7:0] x);
        xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] n);
        logic [7:0] r;
        r = 8'h01;
        case (n)
            4'd1: r = 8'h01;
            4'd2: r = 8'h02;
            4'd3: r = 8'h04;
            4'd4: r = 8'h08;
            4'd5: r = 8'h10;
            4'd6: r = 8'h20;
            4'd7: r = 8'h40;
            4'd8: r = 8'h80;
            4'd9: r = 8'h1b;
            4'd10: r = 8'h36;
            default: r = 8'h00;
        endcase
        rcon = r;
    endfunction

endpackage

// ===== design/aes128_block_encrypt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 block encryptor
// Iterative ECB encryptor with a stored, on-chip expanded key schedule.
// ----------------------------------------------------------------------------
// Usage: write key_high (index 0) and key_low (index 1) through the cfg port
// with cfg_we, cfg_index and cfg_data. Each write made while no block is
// running starts a key expansion that fills the eleven round keys, one per
// cycle, and a new key write restarts it; busy is high meanwhile. After reset
// the same expansion runs for the all-zero key, so busy is high from rst_n
// release until it ends. A block transfer happens at a clock edge with start
// high, busy low and no key write; plain_high and plain_low are sampled
// there. The initial key addition is done on capture, then one round per
// cycle runs through the single shared round unit, reading one stored round
// key each cycle. After the final round the result is shown on cipher_high
// and cipher_low with done high for one cycle. A new block can be started in
// the cycle done is high; none is taken while a block runs. The receiver
// cannot stall; the result stays only until the next block is captured.
// ----------------------------------------------------------------------------
module aes128_block_encrypt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] plain_high,
    input  logic [63:0] plain_low,
    output logic        done,
    output logic [63:0] cipher_high,
    output logic [63:0] cipher_low
);

    aes_pkg::state_t state_reg, state_next;
    logic [3:0]   round_reg, round_next;
    logic [63:0]  key_high_reg, key_low_reg;
    logic [127:0] state_data_reg;
    logic [127:0] exp_key_reg;
    logic         done_reg;

    // Round key store; written during expansion, read one entry per round.
    logic [127:0] rk_mem [11];
    logic [127:0] rk_rd_reg;

    logic [127:0] next_exp_key;
    logic [127:0] round_out;
    logic         key_write;

    assign key_write = cfg_we && (cfg_index == aes_pkg::CFG_KEY_HIGH ||
                                  cfg_index == aes_pkg::CFG_KEY_LOW);

    // Key schedule step: builds entry round_reg from entry round_reg - 1.
    always_comb
    begin
        logic [31:0] w0, w1, w2, w3, t;
        w0 = exp_key_reg[127:96];
        w1 = exp_key_reg[95:64];
        w2 = exp_key_reg[63:32];
        w3 = exp_key_reg[31:0];
        t = {aes_pkg::SBOX[w3[23:16]] ^ aes_pkg::rcon(round_reg),
             aes_pkg::SBOX[w3[15:8]], aes_pkg::SBOX[w3[7:0]],
             aes_pkg::SBOX[w3[31:24]]};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        next_exp_key = {w0, w1, w2, w3};
    end

    // Shared round unit: SubBytes, ShiftRows, MixColumns (skipped on the
    // final round) and AddRoundKey with the registered store read.
    always_comb
    begin
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] m [16];
        logic [7:0] a0, a1, a2, a3;
        for (int i = 0; i < 16; i++)
        begin
            s[i] = state_data_reg[127 - 8*i -: 8];
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[r + 4*c] = aes_pkg::SBOX[s[r + 4*((c + r) % 4)]];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            if (round_reg == 4'(aes_pkg::NUM_ROUNDS))
            begin
                m[4*c] = a0; m[4*c+1] = a1; m[4*c+2] = a2; m[4*c+3] = a3;
            end
            else
            begin
                m[4*c]   = aes_pkg::xtime(a0) ^ aes_pkg::xtime(a1) ^ a1 ^ a2 ^ a3;
                m[4*c+1] = a0 ^ aes_pkg::xtime(a1) ^ aes_pkg::xtime(a2) ^ a2 ^ a3;
                m[4*c+2] = a0 ^ a1 ^ aes_pkg::xtime(a2) ^ aes_pkg::xtime(a3) ^ a3;
                m[4*c+3] = aes_pkg::xtime(a0) ^ a0 ^ a1 ^ a2 ^ aes_pkg::xtime(a3);
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            round_out[127 - 8*i -: 8] = m[i] ^ rk_rd_reg[127 - 8*i -: 8];
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        unique case (state_reg)
            aes_pkg::ST_IDLE:
            begin
                if (key_write)
                begin
                    state_next = aes_pkg::ST_KEYX;
                    round_next = 4'd1;
                end
                else if (start)
                begin
                    state_next = aes_pkg::ST_RUN;
                    round_next = 4'd1;
                end
            end
            aes_pkg::ST_KEYX:
            begin
                if (key_write)
                begin
                    round_next = 4'd1;
                end
                else if (round_reg == 4'(aes_pkg::NUM_ROUNDS))
                begin
                    state_next = aes_pkg::ST_IDLE;
                end
                else
                begin
                    round_next = round_reg + 4'd1;
                end
            end
            aes_pkg::ST_RUN:
            begin
                if (round_reg == 4'(aes_pkg::NUM_ROUNDS))
                begin
                    state_next = aes_pkg::ST_IDLE;
                end
                else
                begin
                    round_next = round_reg + 4'd1;
                end
            end
            default:
            begin
                state_next = aes_pkg::ST_IDLE;
            end
        endcase
    end

    // Output logic.
    always_comb
    begin
        busy = (state_reg != aes_pkg::ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= aes_pkg::ST_KEYX;
            round_reg    <= 4'd1;
            key_high_reg <= '0;
            key_low_reg  <= '0;
            done_reg     <= 1'b0;
            exp_key_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            done_reg  <= (state_reg == aes_pkg::ST_RUN) &&
                         (round_reg == 4'(aes_pkg::NUM_ROUNDS));
            if (cfg_we && cfg_index == aes_pkg::CFG_KEY_HIGH)
            begin
                key_high_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == aes_pkg::CFG_KEY_LOW)
            begin
                key_low_reg <= cfg_data;
            end
            if (key_write)
            begin
                exp_key_reg <= (cfg_index == aes_pkg::CFG_KEY_HIGH) ?
                               {cfg_data, key_low_reg} : {key_high_reg, cfg_data};
            end
            else if (state_reg == aes_pkg::ST_KEYX)
            begin
                exp_key_reg <= next_exp_key;
            end
        end
    end

    // Store write and registered read; the read address runs one ahead.
    // The first expansion step also stores the raw key as entry zero, which
    // covers the expansion that follows reset.
    always_ff @(posedge clk)
    begin
        if (key_write)
        begin
            rk_mem[0] <= (cfg_index == aes_pkg::CFG_KEY_HIGH) ?
                         {cfg_data, key_low_reg} : {key_high_reg, cfg_data};
        end
        else if (state_reg == aes_pkg::ST_KEYX)
        begin
            rk_mem[round_reg] <= next_exp_key;
            if (round_reg == 4'd1)
            begin
                rk_mem[0] <= exp_key_reg;
            end
        end
        if (state_reg == aes_pkg::ST_RUN)
        begin
            rk_rd_reg <= rk_mem[(round_reg == 4'(aes_pkg::NUM_ROUNDS)) ?
                                round_reg : round_reg + 4'd1];
        end
        else
        begin
            rk_rd_reg <= rk_mem[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == aes_pkg::ST_IDLE && !key_write && start)
        begin
            state_data_reg <= {plain_high, plain_low} ^ rk_mem[0];
        end
        else if (state_reg == aes_pkg::ST_RUN)
        begin
            state_data_reg <= round_out;
        end
    end

    assign done        = done_reg;
    assign cipher_high = state_data_reg[127:64];
    assign cipher_low  = state_data_reg[63:0];

endmodule
